### hw/rtl/video_controller_bus_and_line_timing_macros.svh
// assertion macros, clocked on aclk and held off during reset
`ifndef VIDEO_CONTROLLER_BUS_AND_LINE_TIMING_MACROS_SVH
`define VIDEO_CONTROLLER_BUS_AND_LINE_TIMING_MACROS_SVH

`define VCBLT_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define VCBLT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vcblt_pkg.sv
package vcblt_pkg;

    localparam int VRAM_WORDS_DEF  = 32768;
    localparam int LAST_LINE_DEF   = 261;
    localparam int VBLANK_LINE_DEF = 256;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [1:0] PORT_CTRL = 2'd0;
    localparam logic [1:0] PORT_NONE = 2'd1;
    localparam logic [1:0] PORT_LOW  = 2'd2;
    localparam logic [1:0] PORT_HIGH = 2'd3;

    localparam logic [4:0] REG_WADDR  = 5'd0;
    localparam logic [4:0] REG_RADDR  = 5'd1;
    localparam logic [4:0] REG_DATA   = 5'd2;
    localparam logic [4:0] REG_CTRL   = 5'd5;
    localparam logic [4:0] REG_RASTER = 5'd6;

    localparam logic [7:0]  FLAG_RASTER   = 8'h04;
    localparam logic [7:0]  FLAG_VBLANK   = 8'h20;
    localparam logic [15:0] RASTER_OFFSET = 16'd64;

    // reciprocal divide of a 15-bit address by the memory depth
    localparam int RECIP_SHIFT = 30;
    localparam int QUOT_W      = 7;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] port;
        logic [7:0] write_data;
    } item_t;

    typedef struct packed {
        logic       irq;
        logic [7:0] read_data;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    function automatic logic [15:0] addr_step(input logic [1:0] code);
        logic [15:0] s;
        case (code)
            2'd0:    s = 16'd1;
            2'd1:    s = 16'd32;
            2'd2:    s = 16'd64;
            default: s = 16'd128;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] set_byte(input logic [15:0] w, input logic high,
                                             input logic [7:0] b);
        return high ? {b, w[7:0]} : {w[15:8], b};
    endfunction

endpackage

### hw/rtl/video_controller_bus_and_line_timing.sv
// CPU register port and line timing of a tile video controller.
// Input channel s_*: one item is a bus read, a bus write or a scanline tick.
// Output channel m_*: exactly one result item per input item, in order:
// the byte read (zero for writes and ticks) and the interrupt request.
// Each item passes three steps: accept (address divided down to a memory
// index), video memory read, then execute and write back into the
// video memory. The next item is taken only after the last has executed.
// After reset the video memory is swept to zero, one word per cycle, over
// all VRAM_WORDS words (32768 by default); s_tready stays low during the
// sweep.
// The output register holds a result until m_tready; the next item is
// still accepted and read, but its execute step waits for the output
// register to empty, so nothing is lost or repeated under stalls.
module video_controller_bus_and_line_timing import vcblt_pkg::*; #(
    parameter int VRAM_WORDS  = VRAM_WORDS_DEF,
    parameter int LAST_LINE   = LAST_LINE_DEF,
    parameter int VBLANK_LINE = VBLANK_LINE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // write_data
    input  logic [3:0]  s_tuser,  // req_type [1:0], port [3:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // read_data [7:0], irq [8], zero fill
);

    localparam int AW = $clog2(VRAM_WORDS);

    state_t  state_reg, state_next;
    item_t   item_reg;
    item_t   in_item;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    accept;
    logic    exec;
    logic    clear_busy;

    logic          vram_rd_en;
    logic [AW-1:0] vram_rd_idx;
    logic [15:0]   vram_rd_data;
    logic          vram_wr_en;
    logic [AW-1:0] vram_wr_idx;
    logic [15:0]   vram_wr_data;

    assign in_item.req_type   = s_tuser[1:0];
    assign in_item.port       = s_tuser[3:2];
    assign in_item.write_data = s_tdata;

    assign s_tready = (state_reg == ST_IDLE) && !clear_busy;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign exec     = (state_reg == ST_EXEC) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_EXEC;
            ST_EXEC: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
        if (exec) begin
            out_reg <= result;
        end
    end

    vcblt_vram #(
        .VRAM_WORDS (VRAM_WORDS)
    ) u_vram (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (vram_rd_en),
        .rd_idx     (vram_rd_idx),
        .rd_data    (vram_rd_data),
        .wr_en      (vram_wr_en),
        .wr_idx     (vram_wr_idx),
        .wr_data    (vram_wr_data),
        .clear_busy (clear_busy)
    );

    vcblt_regs #(
        .VRAM_WORDS  (VRAM_WORDS),
        .LAST_LINE   (LAST_LINE),
        .VBLANK_LINE (VBLANK_LINE)
    ) u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc      (accept),
        .acc_item (in_item),
        .item     (item_reg),
        .rd_phase (state_reg == ST_READ),
        .exec     (exec),
        .rd_en    (vram_rd_en),
        .rd_idx   (vram_rd_idx),
        .rd_data  (vram_rd_data),
        .wr_en    (vram_wr_en),
        .wr_idx   (vram_wr_idx),
        .wr_data  (vram_wr_data),
        .result   (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.irq, out_reg.read_data};

`include "video_controller_bus_and_line_timing_macros.svh"

    `VCBLT_ASSERT_NEXT(a_accept_to_read, accept, state_reg == ST_READ, "accept did not start read")
    `VCBLT_ASSERT_SAME(a_write_in_exec, vram_wr_en, exec && !clear_busy, "memory write outside execute")
    `VCBLT_ASSERT_NEXT(a_exec_gives_result, exec, m_tvalid, "execute gave no result item")

endmodule

### hw/rtl/vcblt_vram.sv
module vcblt_vram import vcblt_pkg::*; #(
    parameter int VRAM_WORDS = VRAM_WORDS_DEF,
    localparam int AW = $clog2(VRAM_WORDS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_idx,
    output logic [15:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_idx,
    input  logic [15:0]   wr_data,
    output logic          clear_busy
);

    logic [15:0]   words_reg [VRAM_WORDS];
    logic [15:0]   rd_data_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            words_reg[clr_cnt_reg] <= 16'd0;
        end else if (wr_en) begin
            words_reg[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= words_reg[rd_idx];
        end
    end

    // clearing sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(VRAM_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

### hw/rtl/vcblt_regs.sv
module vcblt_regs import vcblt_pkg::*; #(
    parameter int VRAM_WORDS  = VRAM_WORDS_DEF,
    parameter int LAST_LINE   = LAST_LINE_DEF,
    parameter int VBLANK_LINE = VBLANK_LINE_DEF,
    localparam int AW = $clog2(VRAM_WORDS)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          acc,
    input  item_t         acc_item,
    input  item_t         item,
    input  logic          rd_phase,
    input  logic          exec,
    output logic          rd_en,
    output logic [AW-1:0] rd_idx,
    input  logic [15:0]   rd_data,
    output logic          wr_en,
    output logic [AW-1:0] wr_idx,
    output logic [15:0]   wr_data,
    output result_t       result
);

    localparam longint RECIP_L = ((64'sd1 <<< RECIP_SHIFT) + VRAM_WORDS - 1) / VRAM_WORDS;
    localparam logic [21:0] RECIP = 22'(RECIP_L);

    logic [4:0]        sel_reg,    sel_next;
    logic [15:0]       waddr_reg,  waddr_next;
    logic [15:0]       raddr_reg,  raddr_next;
    logic [15:0]       ctrl_reg,   ctrl_next;
    logic [15:0]       raster_reg, raster_next;
    logic [7:0]        status_reg, status_next;
    logic [8:0]        line_reg,   line_next;
    logic [QUOT_W-1:0] quot_reg;
    logic [14:0]       masked_reg;
    logic [AW-1:0]     idx_reg;

    logic [14:0] sel_addr;
    logic [36:0] prod;
    logic [14:0] qn;
    logic [14:0] idx_full;
    logic        high;
    logic [7:0]  st;

    assign sel_addr = (acc_item.req_type == REQ_READ) ? raddr_reg[14:0] : waddr_reg[14:0];
    assign prod     = 37'(sel_addr) * 37'(RECIP);
    assign qn       = 15'(32'(quot_reg) * VRAM_WORDS);
    assign idx_full = masked_reg - qn;

    assign rd_en  = rd_phase;
    assign rd_idx = idx_full[AW-1:0];
    assign wr_idx = idx_reg;
    assign high   = (item.port == PORT_HIGH);

    always_ff @(posedge aclk) begin
        if (acc) begin
            quot_reg   <= prod[RECIP_SHIFT +: QUOT_W];
            masked_reg <= sel_addr;
        end
        if (rd_phase) begin
            idx_reg <= idx_full[AW-1:0];
        end
    end

    always_comb begin
        sel_next    = sel_reg;
        waddr_next  = waddr_reg;
        raddr_next  = raddr_reg;
        ctrl_next   = ctrl_reg;
        raster_next = raster_reg;
        status_next = status_reg;
        line_next   = line_reg;
        wr_en       = 1'b0;
        wr_data     = set_byte(rd_data, high, item.write_data);
        result      = '0;
        st          = status_reg;
        case (item.req_type)
            REQ_READ: begin
                if (item.port == PORT_CTRL) begin
                    result.read_data = status_reg;
                    status_next      = status_reg & ~(FLAG_RASTER | FLAG_VBLANK);
                end else if (item.port != PORT_NONE && sel_reg == REG_DATA) begin
                    if (high) begin
                        result.read_data = rd_data[15:8];
                        raddr_next       = raddr_reg + 16'd1;
                    end else begin
                        result.read_data = rd_data[7:0];
                    end
                end
            end
            REQ_WRITE: begin
                if (item.port == PORT_CTRL) begin
                    sel_next = item.write_data[4:0];
                end else if (item.port != PORT_NONE) begin
                    case (sel_reg)
                        REG_WADDR:  waddr_next  = set_byte(waddr_reg, high, item.write_data);
                        REG_RADDR:  raddr_next  = set_byte(raddr_reg, high, item.write_data);
                        REG_DATA: begin
                            wr_en = exec;
                            if (high) begin
                                waddr_next = waddr_reg + addr_step(ctrl_reg[12:11]);
                            end
                        end
                        REG_CTRL:   ctrl_next   = set_byte(ctrl_reg, high, item.write_data);
                        REG_RASTER: raster_next = set_byte(raster_reg, high, item.write_data);
                        default: ;
                    endcase
                end
            end
            REQ_TICK: begin
                if (16'(line_reg) + RASTER_OFFSET == raster_reg) begin
                    st = status_reg | FLAG_RASTER;
                end else begin
                    st = status_reg & ~FLAG_RASTER;
                end
                if (line_reg == 9'(VBLANK_LINE)) begin
                    st = st | FLAG_VBLANK;
                end
                status_next = st;
                line_next   = (line_reg == 9'(LAST_LINE)) ? 9'd0 : line_reg + 9'd1;
                result.irq  = (ctrl_reg[3] && (st & FLAG_VBLANK) != 8'd0) ||
                              (ctrl_reg[2] && (st & FLAG_RASTER) != 8'd0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg    <= '0;
            waddr_reg  <= '0;
            raddr_reg  <= '0;
            ctrl_reg   <= '0;
            raster_reg <= '0;
            status_reg <= '0;
            line_reg   <= '0;
        end else if (exec) begin
            sel_reg    <= sel_next;
            waddr_reg  <= waddr_next;
            raddr_reg  <= raddr_next;
            ctrl_reg   <= ctrl_next;
            raster_reg <= raster_next;
            status_reg <= status_next;
            line_reg   <= line_next;
        end
    end

endmodule
